[rtl/differential_drive_odometry_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the odometry block
// Concurrent checks on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

`ifndef SYNTHESIS
`define DDO_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define DDO_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DDO_ASSERT_HOLDS(lbl, cond, msg)
`define DDO_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/ddo_pkg.sv]
// ---------------------------------------------------------------------------
// ddo_pkg
// Types, constants and tables shared by the odometry modules.
// ---------------------------------------------------------------------------
package ddo_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 34;
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 34;
	localparam int COR_W   = 34;

	localparam int ADDR_W = 3;
	localparam int DPC_W  = 16;
	localparam int TW_W   = 23;

	localparam logic REG_DPC = 1'b0;
	localparam logic REG_TW  = 1'b1;

	localparam logic [DPC_W-1:0] DPC_RESET = 16'd1000;
	localparam logic [TW_W-1:0]  TW_RESET  = 23'd983040;

	localparam logic signed [MUL_B_W-1:0] INV_PI_BAM      = 34'sd683565276;
	localparam logic signed [MUL_B_W-1:0] PI_Q30          = 34'sd3373259426;
	localparam logic signed [COR_W-1:0]   CORDIC_GAIN_INV = 34'sd652032874;
	localparam logic signed [63:0]        SMALL_HALF      = 64'sd8388608;
	localparam logic signed [DIV_D_W-1:0] DIV_SIX         = 34'sd6;
	localparam logic signed [33:0]        ONE_Q30         = 34'sd1073741824;

	localparam logic [29:0] ATAN_BAM [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81,
		30'd41, 30'd20, 30'd10, 30'd5,
		30'd3, 30'd1, 30'd1, 30'd0
	};

	typedef struct packed {
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} ddo_count_t;

	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] y_position;
		logic        [31:0] heading;
	} ddo_pose_t;

endpackage

[rtl/ddo_cfg.sv]
// ---------------------------------------------------------------------------
// ddo_cfg
// APB register file: distance per count and track width.
// ---------------------------------------------------------------------------
module ddo_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ddo_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [ddo_pkg::DPC_W-1:0]   dpc,
	output logic [ddo_pkg::TW_W-1:0]    tw
);
	import ddo_pkg::*;

	logic [DPC_W-1:0] dpc_q;
	logic [TW_W-1:0]  tw_q;
	logic             wr_en;
	logic             idx;

	assign idx    = paddr[2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= DPC_RESET;
			tw_q  <= TW_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_DPC: dpc_q <= pwdata[DPC_W-1:0];
				REG_TW:  tw_q  <= pwdata[TW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DPC: prdata = 32'(dpc_q);
			REG_TW:  prdata = 32'(tw_q);
			default: prdata = '0;
		endcase
	end

	assign dpc = dpc_q;
	assign tw  = tw_q;

endmodule

[rtl/ddo_mul.sv]
// ---------------------------------------------------------------------------
// ddo_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// ---------------------------------------------------------------------------
module ddo_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ddo_pkg::MUL_A_W-1:0] a,
	input  logic signed [ddo_pkg::MUL_B_W-1:0] b,
	output logic                               busy,
	output logic                               done,
	output logic signed [ddo_pkg::MUL_A_W-1:0] p
);
	import ddo_pkg::*;

	localparam int CW = $clog2(MUL_B_W);
	localparam logic [CW-1:0] LAST = CW'(MUL_B_W - 1);

	logic signed [MUL_A_W-1:0] a_q;
	logic signed [MUL_A_W-1:0] acc_q;
	logic signed [MUL_B_W-1:0] b_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic signed [MUL_A_W-1:0] addend;

	// the top bit of the multiplier weighs negative
	always_comb begin
		if (!b_q[0])
			addend = '0;
		else if (cnt_q == LAST)
			addend = -a_q;
		else
			addend = a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
			a_q   <= a_q <<< 1;
			b_q   <= b_q >>> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p    = acc_q;

endmodule

[rtl/ddo_div.sv]
// ---------------------------------------------------------------------------
// ddo_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
module ddo_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ddo_pkg::DIV_N_W-1:0] n,
	input  logic signed [ddo_pkg::DIV_D_W-1:0] d,
	output logic                               busy,
	output logic                               done,
	output logic signed [ddo_pkg::DIV_N_W-1:0] q
);
	import ddo_pkg::*;

	localparam int CW = $clog2(DIV_N_W);
	localparam logic [CW-1:0] LAST = CW'(DIV_N_W - 1);

	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dm_q;
	logic               neg_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   trial;
	logic               fits;
	logic [DIV_D_W:0]   rem_sub;

	assign trial   = {rem_q, quo_q[DIV_N_W-1]};
	assign fits    = trial >= {1'b0, dm_q};
	assign rem_sub = trial - {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= n[DIV_N_W-1] ? DIV_N_W'(-n) : DIV_N_W'(n);
			dm_q  <= d[DIV_D_W-1] ? DIV_D_W'(-d) : DIV_D_W'(d);
			rem_q <= '0;
			neg_q <= n[DIV_N_W-1] ^ d[DIV_D_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign q    = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule

[rtl/ddo_cordic.sv]
// ---------------------------------------------------------------------------
// ddo_cordic
// Iterative CORDIC rotation: one micro-rotation per cycle, gives cos and sin
// of a binary angle in Q4.30.
// ---------------------------------------------------------------------------
module ddo_cordic #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [31:0]                      ang,
	output logic                             busy,
	output logic                             done,
	output logic signed [ddo_pkg::COR_W-1:0] cos_v,
	output logic signed [ddo_pkg::COR_W-1:0] sin_v
);
	import ddo_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

	logic signed [COR_W-1:0] x_q, y_q, z_q;
	logic [1:0]              quad_q;
	logic [IW-1:0]           i_q;
	logic                    busy_q;
	logic                    done_q;
	logic [31:0]             ang_r;
	logic [1:0]              quad;
	logic [31:0]             resid;
	logic signed [COR_W-1:0] xs, ys, at;

	// nearest quarter turn, residual within an eighth turn
	assign ang_r = ang + 32'h2000_0000;
	assign quad  = ang_r[31:30];
	assign resid = ang - {quad, 30'd0};

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = COR_W'(ATAN_BAM[5'(i_q)]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN_INV;
			y_q    <= '0;
			z_q    <= COR_W'(signed'(resid));
			quad_q <= quad;
		end else if (busy_q) begin
			if (!z_q[COR_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_v = x_q;
				sin_v = y_q;
			end
			2'd1: begin
				cos_v = -y_q;
				sin_v = x_q;
			end
			2'd2: begin
				cos_v = -x_q;
				sin_v = -y_q;
			end
			default: begin
				cos_v = y_q;
				sin_v = -x_q;
			end
		endcase
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

[rtl/differential_drive_odometry.sv]
// ---------------------------------------------------------------------------
// differential_drive_odometry
// Two-wheel odometry, arc model, in fixed point.
// ---------------------------------------------------------------------------
// Input channel count (count_valid/count_ready) takes absolute left and right
// encoder counts; output channel pose (pose_valid/pose_ready) returns x, y in
// Q16.16 and the heading as a binary angle. One pose per count transfer.
// Registers on the APB port: distance per count at 0x0, track width at 0x4.
// All arithmetic runs through one bit-serial multiplier, one restoring divider
// and one iterative CORDIC, called in turn by a step sequencer.
// The block takes one item at a time: count_ready is high only while the
// sequencer is idle. A finished pose sits in an output register, so the next
// count is accepted while it waits; a stalled receiver holds the block only
// when the following pose is ready to commit.
// Reset clears position, heading and previous counts to zero and loads the
// register reset values.
// ---------------------------------------------------------------------------
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       count_valid,
	output logic                       count_ready,
	input  ddo_pkg::ddo_count_t        count,
	output logic                       pose_valid,
	input  logic                       pose_ready,
	output ddo_pkg::ddo_pose_t         pose,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ddo_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import ddo_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_ML   = 5'd1;
	localparam logic [4:0] ST_MR   = 5'd2;
	localparam logic [4:0] ST_MA   = 5'd3;
	localparam logic [4:0] ST_DA   = 5'd4;
	localparam logic [4:0] ST_MU   = 5'd5;
	localparam logic [4:0] ST_MUU  = 5'd6;
	localparam logic [4:0] ST_D6   = 5'd7;
	localparam logic [4:0] ST_MH   = 5'd8;
	localparam logic [4:0] ST_CH   = 5'd9;
	localparam logic [4:0] ST_MT   = 5'd10;
	localparam logic [4:0] ST_MTW  = 5'd11;
	localparam logic [4:0] ST_DT   = 5'd12;
	localparam logic [4:0] ST_CD   = 5'd13;
	localparam logic [4:0] ST_MX   = 5'd14;
	localparam logic [4:0] ST_MY   = 5'd15;
	localparam logic [4:0] ST_OUT  = 5'd16;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	logic [DPC_W-1:0] dpc;
	logic [TW_W-1:0]  tw;
	logic [TW_W-1:0]  w;

	logic [4:0]          state_q;
	logic                issue_q;
	logic [31:0]         lc_q, rc_q;
	logic [31:0]         prev_left_q, prev_right_q;
	logic [31:0]         heading_q;
	logic signed [31:0]  x_q, y_q;
	logic signed [31:0]  dl_q, dr_q, h_q;
	logic signed [63:0]  alpha_q, half_q;
	logic signed [33:0]  u_q, sc_q;
	logic signed [35:0]  t_q;
	logic                pose_valid_q;
	ddo_pose_t           pose_q;

	logic signed [32:0]  sum, diff;
	logic signed [31:0]  dist_n;
	logic signed [63:0]  half_n;
	logic                is_mul, is_div, is_cor;
	logic                unit_done;
	logic                commit;

	logic                      mul_start, mul_busy, mul_done;
	logic signed [MUL_A_W-1:0] mul_a, mul_p;
	logic signed [MUL_B_W-1:0] mul_b;
	logic                      div_start, div_busy, div_done;
	logic signed [DIV_N_W-1:0] div_n, div_q;
	logic signed [DIV_D_W-1:0] div_d;
	logic                      cor_start, cor_busy, cor_done;
	logic [31:0]               cor_ang;
	logic signed [COR_W-1:0]   cor_cos, cor_sin;

	ddo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dpc     (dpc),
		.tw      (tw)
	);

	ddo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.p      (mul_p)
	);

	ddo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.busy   (div_busy),
		.done   (div_done),
		.q      (div_q)
	);

	ddo_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.ang    (cor_ang),
		.busy   (cor_busy),
		.done   (cor_done),
		.cos_v  (cor_cos),
		.sin_v  (cor_sin)
	);

	// a zero track width acts as one
	assign w      = (tw == '0) ? TW_W'(1) : tw;
	assign sum    = 33'(dl_q) + 33'(dr_q);
	assign diff   = 33'(dr_q) - 33'(dl_q);
	assign dist_n = sat32(mul_p >>> 8);
	assign half_n = div_q >>> 1;

	always_comb begin
		is_mul = state_q inside {ST_ML, ST_MR, ST_MA, ST_MU, ST_MUU, ST_MH,
			ST_MT, ST_MTW, ST_MX, ST_MY};
		is_div = state_q inside {ST_DA, ST_D6, ST_DT};
		is_cor = state_q inside {ST_CH, ST_CD};
	end

	assign mul_start = issue_q && is_mul;
	assign div_start = issue_q && is_div;
	assign cor_start = issue_q && is_cor;
	assign unit_done = !issue_q && ((is_mul && mul_done) || (is_div && div_done) ||
		(is_cor && cor_done));

	always_comb begin
		case (state_q)
			ST_ML: begin
				mul_a = 64'(signed'(lc_q - prev_left_q));
				mul_b = 34'(dpc);
			end
			ST_MR: begin
				mul_a = 64'(signed'(rc_q - prev_right_q));
				mul_b = 34'(dpc);
			end
			ST_MA: begin
				mul_a = 64'(diff);
				mul_b = INV_PI_BAM;
			end
			ST_MU: begin
				mul_a = half_q;
				mul_b = PI_Q30;
			end
			ST_MUU: begin
				mul_a = 64'(u_q);
				mul_b = u_q;
			end
			ST_MH: begin
				mul_a = 64'(sum);
				mul_b = sc_q;
			end
			ST_MT: begin
				mul_a = 64'(sum);
				mul_b = cor_sin;
			end
			ST_MTW: begin
				mul_a = 64'(t_q);
				mul_b = 34'(w);
			end
			ST_MX: begin
				mul_a = 64'(h_q);
				mul_b = cor_cos;
			end
			ST_MY: begin
				mul_a = 64'(h_q);
				mul_b = cor_sin;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_DA: begin
				div_n = mul_p;
				div_d = 34'(w);
			end
			ST_D6: begin
				div_n = mul_p >>> 30;
				div_d = DIV_SIX;
			end
			ST_DT: begin
				div_n = mul_p;
				div_d = 34'(diff);
			end
			default: begin
				div_n = '0;
				div_d = DIV_SIX;
			end
		endcase
	end

	// half-turn sine first, then the travel direction
	assign cor_ang = (state_q == ST_CH) ? half_q[31:0] : heading_q + half_q[31:0];

	assign commit = (state_q == ST_OUT) && (!pose_valid_q || pose_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_q      <= 1'b0;
			prev_left_q  <= '0;
			prev_right_q <= '0;
			heading_q    <= '0;
			x_q          <= '0;
			y_q          <= '0;
			pose_valid_q <= 1'b0;
		end else begin
			if (pose_valid_q && pose_ready)
				pose_valid_q <= 1'b0;
			if (state_q == ST_IDLE) begin
				if (count_valid) begin
					state_q <= ST_ML;
					issue_q <= 1'b1;
				end
			end else if (state_q == ST_OUT) begin
				if (commit) begin
					heading_q    <= heading_q + alpha_q[31:0];
					prev_left_q  <= lc_q;
					prev_right_q <= rc_q;
					pose_valid_q <= 1'b1;
					state_q      <= ST_IDLE;
				end
			end else if (issue_q) begin
				issue_q <= 1'b0;
			end else if (unit_done) begin
				issue_q <= 1'b1;
				case (state_q)
					ST_ML:  state_q <= ST_MR;
					ST_MR:  state_q <= (dist_n == dl_q) ? ST_CD : ST_MA;
					ST_MA:  state_q <= ST_DA;
					ST_DA: begin
						if (half_n < SMALL_HALF && half_n > -SMALL_HALF)
							state_q <= ST_MU;
						else
							state_q <= ST_CH;
					end
					ST_MU:  state_q <= ST_MUU;
					ST_MUU: state_q <= ST_D6;
					ST_D6:  state_q <= ST_MH;
					ST_MH:  state_q <= ST_CD;
					ST_CH:  state_q <= ST_MT;
					ST_MT:  state_q <= ST_MTW;
					ST_MTW: state_q <= ST_DT;
					ST_DT:  state_q <= ST_CD;
					ST_CD:  state_q <= ST_MX;
					ST_MX: begin
						x_q     <= sat32(64'(x_q) + (mul_p >>> 30));
						state_q <= ST_MY;
					end
					ST_MY: begin
						y_q     <= sat32(64'(y_q) + (mul_p >>> 30));
						state_q <= ST_OUT;
						issue_q <= 1'b0;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && count_valid) begin
			lc_q <= count.left_count;
			rc_q <= count.right_count;
		end
		if (unit_done) begin
			case (state_q)
				ST_ML: dl_q <= dist_n;
				ST_MR: begin
					dr_q <= dist_n;
					// equal distances: straight step along the old heading
					if (dist_n == dl_q) begin
						h_q     <= dist_n;
						alpha_q <= '0;
						half_q  <= '0;
					end
				end
				ST_DA: begin
					alpha_q <= div_q;
					half_q  <= half_n;
				end
				ST_MU:  u_q  <= 34'(mul_p >>> 31);
				ST_D6:  sc_q <= ONE_Q30 - 34'(div_q);
				ST_MH:  h_q  <= sat32(mul_p >>> 31);
				ST_MT:  t_q  <= 36'(mul_p >>> 30);
				ST_DT:  h_q  <= sat32(div_q);
				default: ;
			endcase
		end
		if (commit) begin
			pose_q.x_position <= x_q;
			pose_q.y_position <= y_q;
			pose_q.heading    <= heading_q + alpha_q[31:0];
		end
	end

	assign count_ready = (state_q == ST_IDLE);
	assign pose_valid  = pose_valid_q;
	assign pose        = pose_q;

	`DDO_ASSERT_HOLDS(a_one_unit, $onehot0({mul_busy, div_busy, cor_busy}), "two arithmetic units busy at once")
	`DDO_ASSERT_IMPLIES(a_idle_quiet, state_q == ST_IDLE, !mul_busy && !div_busy && !cor_busy, "unit busy while sequencer idle")
	`DDO_ASSERT_IMPLIES(a_pose_commit, $rose(pose_valid), $past(state_q == ST_OUT), "pose raised outside commit")
	`DDO_ASSERT_NEXT(a_take_starts, count_valid && count_ready, state_q == ST_ML && issue_q, "count transfer did not start a step")

endmodule
